>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Plain text macros only; each use expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/mbet_pkg.sv
// Shared types and constants of the escape-time point evaluator.
// No dependencies; imported by the multiplier, the top level and the checker.
package mbet_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned PIX_W     = 13;
  localparam int unsigned STEP_W    = 31;
  localparam int unsigned C_W       = PIX_W + STEP_W;
  localparam int unsigned ITER_W    = 10;
  localparam int unsigned COLOR_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Color map constants.
  localparam int unsigned COLOR_SCALE = 11;
  localparam int unsigned COLOR_MAX   = 255;

  // Register reset values.
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(550);
  localparam logic [STEP_W-1:0] X_STEP_RST   = STEP_W'(223696);
  localparam logic [STEP_W-1:0] Y_STEP_RST   = STEP_W'(223696);

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP   = 2'd2;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CX,
    ST_CY,
    ST_ZXY,
    ST_RANGE,
    ST_SQX,
    ST_SQY,
    ST_MAG,
    ST_FIN
  } mbet_state_t;

  // Request to the shared multiplier.
  typedef struct packed {
    logic start;
    logic neg;
  } mbet_mul_ctl_t;

endpackage

>>> hw/rtl/mbet_mul.sv
// Shared multi-cycle signed multiplier built from four half-width limb products.
// Depends on mbet_pkg for the request struct.
module mbet_mul #(
  parameter int unsigned MW = 31
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mbet_pkg::mbet_mul_ctl_t   ctl,
  input  logic [MW-1:0]             a,
  input  logic [MW-1:0]             b,
  output logic                      done,
  output logic signed [4*((MW+1)/2):0] prod
);
  import mbet_pkg::*;

  localparam int unsigned LW = (MW + 1) / 2;
  localparam int unsigned PW = 4 * LW;

  logic [2*LW-1:0] a_r;
  logic [2*LW-1:0] b_r;
  logic            neg_r;
  logic            run;
  logic [2:0]      cnt;
  logic            pp_vld;
  logic [1:0]      pp_sh;
  logic [2*LW-1:0] pp;
  logic [PW-1:0]   acc;
  logic [LW-1:0]   a_limb;
  logic [LW-1:0]   b_limb;
  logic [PW-1:0]   pp_shifted;

  // Limb selection: bit 1 of the count picks the half of a, bit 0 that of b.
  assign a_limb = cnt[1] ? a_r[2*LW-1:LW] : a_r[LW-1:0];
  assign b_limb = cnt[0] ? b_r[2*LW-1:LW] : b_r[LW-1:0];

  // Align a registered limb product to its weight.
  always_comb begin
    case (pp_sh)
      2'd0:    pp_shifted = PW'(pp);
      2'd1:    pp_shifted = PW'(pp) << LW;
      default: pp_shifted = PW'(pp) << (2 * LW);
    endcase
  end

  // Control: four limb products, a trailing accumulate, then the sign step with done.
  always_ff @(posedge clk) begin
    if (rst) begin
      run    <= 1'b0;
      cnt    <= '0;
      pp_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        run    <= 1'b1;
        cnt    <= '0;
        pp_vld <= 1'b0;
      end else if (run) begin
        pp_vld <= !cnt[2];
        if (!cnt[2]) begin
          cnt <= cnt + 3'd1;
        end else if (!pp_vld) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: operand capture, limb product, accumulation and final sign.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= (2*LW)'(a);
      b_r   <= (2*LW)'(b);
      neg_r <= ctl.neg;
      acc   <= '0;
    end else if (run) begin
      if (!cnt[2]) begin
        pp    <= a_limb * b_limb;
        pp_sh <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
      end
      if (pp_vld) begin
        acc <= acc + pp_shifted;
      end
      if (cnt[2] && !pp_vld) begin
        prod <= neg_r ? -$signed({1'b0, acc}) : $signed({1'b0, acc});
      end
    end
  end

endmodule

>>> hw/rtl/mandelbrot_escape_time.sv
// Escape-time evaluator: one pixel word in, one color word out, one word at a time.
// c is formed first with two products, then the iterations run on one shared multiplier,
// three products per iteration.
// busy stays high from accept until the done cycle; the next word is taken in the cycle after it.
// Results are strobed by done for one cycle and cannot be held off.
// Reset (rst, synchronous) returns to idle and loads the register defaults.
module mandelbrot_escape_time #(
  parameter int unsigned FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic signed [mbet_pkg::PIX_W-1:0]    pixel_x,
  input  logic signed [mbet_pkg::PIX_W-1:0]    pixel_y,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mbet_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mbet_pkg::STEP_W-1:0]          cfg_data,
  output logic                                 done,
  output logic [mbet_pkg::ITER_W-1:0]          iterations,
  output logic                                 escaped,
  output logic [mbet_pkg::COLOR_W-1:0]         red,
  output logic [mbet_pkg::COLOR_W-1:0]         blue
);
  import mbet_pkg::*;

  // Operand width covers both |z| <= 2.0 and the pixel step.
  localparam int unsigned MW  = (FRAC_BITS + 2 > STEP_W) ? FRAC_BITS + 2 : STEP_W;
  localparam int unsigned LW  = (MW + 1) / 2;
  localparam int unsigned PW  = 4 * LW;
  localparam int unsigned ZW  = FRAC_BITS + 3;
  localparam int unsigned SQW = FRAC_BITS + 3;
  localparam int unsigned NW  = ((FRAC_BITS + 5 > C_W) ? FRAC_BITS + 5 : C_W) + 1;
  localparam int unsigned CLW = ITER_W + 4;

  localparam logic signed [NW-1:0] TWO   = NW'(64'd2 << FRAC_BITS);
  localparam logic signed [NW-1:0] M_TWO = -TWO;
  localparam logic [SQW:0]         FOUR  = (SQW+1)'(64'd4 << FRAC_BITS);

  mbet_state_t state, state_next;

  logic [ITER_W-1:0]        max_iterations;
  logic [STEP_W-1:0]        x_step;
  logic [STEP_W-1:0]        y_step;

  logic signed [PIX_W-1:0]  px_r;
  logic signed [PIX_W-1:0]  py_r;
  logic signed [C_W-1:0]    cx;
  logic signed [C_W-1:0]    cy;
  logic signed [ZW-1:0]     zx;
  logic signed [ZW-1:0]     zy;
  logic [SQW-1:0]           sqx;
  logic [SQW-1:0]           sqy;
  logic signed [NW-1:0]     nx;
  logic signed [NW-1:0]     ny;
  logic [ITER_W-1:0]        iter;
  logic [ITER_W-1:0]        res_iter;
  logic                     res_esc;
  logic                     issued;

  mbet_mul_ctl_t            mul_ctl;
  logic [MW-1:0]            mul_a;
  logic [MW-1:0]            mul_b;
  logic                     mul_done;
  logic signed [PW:0]       mul_prod;
  logic                     mul_state;

  logic signed [PIX_W:0]    px_ext;
  logic signed [PIX_W:0]    py_ext;
  logic [PIX_W:0]           px_mag;
  logic [PIX_W:0]           py_mag;
  logic [ZW-1:0]            zx_mag;
  logic [ZW-1:0]            zy_mag;
  logic [NW-1:0]            nx_mag;
  logic [NW-1:0]            ny_mag;

  logic signed [NW-1:0]     nx_calc;
  logic signed [NW-1:0]     ny_calc;
  logic                     out_range;
  logic                     mag_esc;
  logic                     last_iter;
  logic [CLW-1:0]           scaled;
  logic [COLOR_W-1:0]       red_val;

  // Configuration registers; the port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iterations <= MAX_ITER_RST;
      x_step         <= X_STEP_RST;
      y_step         <= Y_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITER: max_iterations <= cfg_data[ITER_W-1:0];
        REG_X_STEP:   x_step         <= cfg_data;
        REG_Y_STEP:   y_step         <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Magnitudes of the multiplier operands.
  assign px_ext = {px_r[PIX_W-1], px_r};
  assign py_ext = {py_r[PIX_W-1], py_r};
  assign px_mag = px_ext[PIX_W] ? -px_ext : px_ext;
  assign py_mag = py_ext[PIX_W] ? -py_ext : py_ext;
  assign zx_mag = zx[ZW-1] ? -zx : zx;
  assign zy_mag = zy[ZW-1] ? -zy : zy;
  assign nx_mag = nx[NW-1] ? -nx : nx;
  assign ny_mag = ny[NW-1] ? -ny : ny;

  // Request and operand selection for the shared multiplier, by state.
  always_comb begin
    mul_ctl.start = mul_state && !issued;
    mul_a         = '0;
    mul_b         = '0;
    mul_ctl.neg   = 1'b0;
    case (state)
      ST_CX: begin
        mul_a       = MW'(px_mag);
        mul_b       = MW'(x_step);
        mul_ctl.neg = px_r[PIX_W-1];
      end
      ST_CY: begin
        mul_a       = MW'(py_mag);
        mul_b       = MW'(y_step);
        mul_ctl.neg = py_r[PIX_W-1];
      end
      ST_ZXY: begin
        mul_a       = MW'(zx_mag);
        mul_b       = MW'(zy_mag);
        mul_ctl.neg = zx[ZW-1] ^ zy[ZW-1];
      end
      ST_SQX: begin
        mul_a = MW'(nx_mag);
        mul_b = MW'(nx_mag);
      end
      ST_SQY: begin
        mul_a = MW'(ny_mag);
        mul_b = MW'(ny_mag);
      end
      default: ;
    endcase
  end

  mbet_mul #(
    .MW (MW)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  // Next z: real part from the stored squares, imaginary part from 2*zx*zy.
  assign nx_calc = NW'(sqx) - NW'(sqy) + NW'(cx);
  assign ny_calc = NW'(mul_prod >>> (FRAC_BITS - 1)) + NW'(cy);

  // Escape tests: a coordinate beyond 2.0, or |z|^2 beyond 4.0.
  assign out_range = (nx > TWO) || (nx < M_TWO) || (ny > TWO) || (ny < M_TWO);
  assign mag_esc   = ({1'b0, sqx} + {1'b0, sqy}) > FOUR;
  assign last_iter = (iter == max_iterations - ITER_W'(1));

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = (max_iterations == '0) ? ST_FIN : ST_CX;
      ST_CX:    if (mul_done) state_next = ST_CY;
      ST_CY:    if (mul_done) state_next = ST_ZXY;
      ST_ZXY:   if (mul_done) state_next = ST_RANGE;
      ST_RANGE: state_next = out_range ? ST_FIN : ST_SQX;
      ST_SQX:   if (mul_done) state_next = ST_SQY;
      ST_SQY:   if (mul_done) state_next = ST_MAG;
      ST_MAG:   state_next = (mag_esc || last_iter) ? ST_FIN : ST_ZXY;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy      = 1'b1;
    done      = 1'b0;
    mul_state = 1'b0;
    unique case (state) inside
      ST_IDLE:  busy = 1'b0;
      ST_CX, ST_CY, ST_ZXY, ST_SQX, ST_SQY: mul_state = 1'b1;
      ST_RANGE, ST_MAG: ;
      ST_FIN:   done = 1'b1;
      default:  ;
    endcase
  end

  // Sequencer state and the one-request-per-state flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_ctl.start) begin
        issued <= 1'b1;
      end else if (mul_done) begin
        issued <= 1'b0;
      end
    end
  end

  // Point datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          px_r     <= pixel_x;
          py_r     <= pixel_y;
          iter     <= '0;
          zx       <= '0;
          zy       <= '0;
          sqx      <= '0;
          sqy      <= '0;
          res_esc  <= 1'b0;
          res_iter <= '0;
        end
      end
      ST_CX:  if (mul_done) cx <= mul_prod[C_W-1:0];
      ST_CY:  if (mul_done) cy <= mul_prod[C_W-1:0];
      ST_ZXY: begin
        if (mul_done) begin
          nx <= nx_calc;
          ny <= ny_calc;
        end
      end
      ST_RANGE: begin
        if (out_range) begin
          res_esc  <= 1'b1;
          res_iter <= iter;
        end
      end
      ST_SQX: if (mul_done) sqx <= SQW'(mul_prod >>> FRAC_BITS);
      ST_SQY: if (mul_done) sqy <= SQW'(mul_prod >>> FRAC_BITS);
      ST_MAG: begin
        if (mag_esc) begin
          res_esc  <= 1'b1;
          res_iter <= iter;
        end else begin
          zx   <= ZW'(nx);
          zy   <= ZW'(ny);
          iter <= iter + ITER_W'(1);
        end
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  // Color map: red saturates at full scale, blue is its complement, black inside.
  assign scaled  = CLW'(res_iter) * CLW'(COLOR_SCALE);
  assign red_val = (scaled > CLW'(COLOR_MAX)) ? COLOR_W'(COLOR_MAX) : scaled[COLOR_W-1:0];

  assign iterations = res_iter;
  assign escaped    = res_esc;
  assign red        = res_esc ? red_val : '0;
  assign blue       = res_esc ? COLOR_W'(COLOR_MAX) - red_val : '0;

endmodule

>>> hw/rtl/mbet_checker.sv
// Port-level checker for the escape-time evaluator, bound to the top level.
// Depends on mbet_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbet_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [mbet_pkg::ITER_W-1:0]   iterations,
  input logic                          escaped,
  input logic [mbet_pkg::COLOR_W-1:0]  red,
  input logic [mbet_pkg::COLOR_W-1:0]  blue
);
  import mbet_pkg::*;

  // A result word is shown while the block still counts as busy.
  `ASSERT_SAME(a_done_busy, clk, rst, done, busy, "done while the block is idle")

  // The done strobe is high for a single cycle.
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "done held for more than one cycle")

  // An accepted word makes the block busy in the next cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accepted word left block idle")

  // A point inside the set is reported black with a zero count.
  `ASSERT_SAME(a_inside_black, clk, rst, done && !escaped,
    (iterations == '0) && (red == '0) && (blue == '0), "inside point not black")

  // For an escaped point blue complements red.
  `ASSERT_SAME(a_color_sum, clk, rst, done && escaped,
    (9'(red) + 9'(blue)) == 9'(COLOR_MAX), "red and blue do not sum to full scale")

endmodule

bind mandelbrot_escape_time mbet_checker u_mbet_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .iterations (iterations),
  .escaped    (escaped),
  .red        (red),
  .blue       (blue)
);
